// ----- sv/ordered_record_list_defines.svh -----
// assertion macros shared by the ordered record list
`ifndef ORDERED_RECORD_LIST_DEFINES_SVH
`define ORDERED_RECORD_LIST_DEFINES_SVH

// same-cycle implication, checked out of reset
`define ORL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define ORL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/orl_pkg.sv -----
// types, codes and defaults of the ordered record list
package orl_pkg;

    localparam int ORL_LIST_DEPTH = 16;

    typedef enum logic [2:0] {
        CMD_INS_FRONT = 3'd0,
        CMD_INS_BACK  = 3'd1,
        CMD_INS_POS   = 3'd2,
        CMD_SEARCH    = 3'd3,
        CMD_DEL_FRONT = 3'd4,
        CMD_DEL_BACK  = 3'd5
    } t_command;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_BADPOS   = 3'd2,
        ST_FULL     = 3'd3,
        ST_NOTFOUND = 3'd4
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_SEARCH
    } t_state;

    typedef struct packed {
        logic [2:0]  command;
        logic [3:0]  position;
        logic [63:0] team_name;
        logic [63:0] leader_name;
        logic [63:0] language_name;
        logic [15:0] member_count;
    } t_cmd_in;

    typedef struct packed {
        logic [2:0] status;
        logic [3:0] found_index;
        logic [4:0] entry_count;
    } t_result;

    typedef struct packed {
        logic [63:0] team_name;
        logic [63:0] leader_name;
        logic [63:0] language_name;
        logic [15:0] member_count;
    } t_record;

    // broadcast control from the sequencer to every cell
    typedef struct packed {
        logic ins;
        logic del;
        logic probe_start;
        logic probe_step;
        logic probe_clear;
    } t_cell_cmd;

endpackage

// ----- sv/ordered_record_list.sv -----
// top level of the ordered record list: sequencer plus a chain of record cells
// inserts and removes: result strobe in the cycle after the transfer, one command per cycle while no search is busy
// search: a token walks the cells one per cycle from index 0, and the result strobe follows the first
//   hit, or the last record on a miss; busy is high while the token walks
// reset (synchronous, active low) empties the list and clears the token and strobe
`include "ordered_record_list_defines.svh"
module ordered_record_list #(
    parameter int LIST_DEPTH = orl_pkg::ORL_LIST_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  orl_pkg::t_cmd_in i_cmd,
    output logic             o_done,
    output orl_pkg::t_result o_result
);
    import orl_pkg::*;

    localparam int IW   = $clog2(LIST_DEPTH);
    localparam int CW   = $clog2(LIST_DEPTH + 1);
    localparam int CMPW = (CW > 4) ? CW : 4;

    t_state              r_state;
    t_state              n_state;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;
    logic [IW-1:0]       r_scan;
    logic [IW-1:0]       n_scan;
    logic [63:0]         r_key;
    logic [63:0]         n_key;
    logic                r_done;
    logic                n_done;
    t_result             r_result;
    t_result             n_result;

    t_cell_cmd           cell_cmd;
    logic [IW-1:0]       cell_at;
    t_record             new_rec;
    t_record             cell_rec [LIST_DEPTH];
    logic [LIST_DEPTH-1:0] cell_probe;
    logic [LIST_DEPTH-1:0] cell_match;

    logic                accept;
    logic                is_empty;
    logic                is_full;
    logic                hit;
    logic                scan_last;
    logic [CMPW-1:0]     pos_w;
    logic [CMPW-1:0]     cnt_w;
    logic [CW+4:0]       count_ext;
    logic [IW+3:0]       scan_ext;

    // command decode helpers
    assign accept    = start && !busy;
    assign is_empty  = (r_count == '0);
    assign is_full   = (r_count == CW'(LIST_DEPTH));
    assign hit       = |cell_match;
    assign scan_last = (CW'(r_scan) == CW'(r_count - CW'(1)));
    assign pos_w     = CMPW'(i_cmd.position);
    assign cnt_w     = CMPW'(r_count);
    assign count_ext = (CW + 5)'(n_count);
    assign scan_ext  = (IW + 4)'(r_scan);
    assign new_rec   = '{team_name:     i_cmd.team_name,
                         leader_name:   i_cmd.leader_name,
                         language_name: i_cmd.language_name,
                         member_count:  i_cmd.member_count};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && (i_cmd.command == CMD_SEARCH) && !is_empty) begin
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (hit || scan_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // cell control, count update and result
    always_comb begin
        cell_cmd             = '0;
        cell_at              = '0;
        n_count              = r_count;
        n_scan               = r_scan;
        n_key                = r_key;
        n_done               = 1'b0;
        n_result.status      = ST_OK;
        n_result.found_index = '0;
        n_result.entry_count = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_done = 1'b1;
                    case (i_cmd.command)
                        CMD_INS_FRONT: begin
                            if (is_full) begin
                                n_result.status = ST_FULL;
                            end else begin
                                cell_cmd.ins = 1'b1;
                                n_count      = r_count + CW'(1);
                            end
                        end
                        CMD_INS_BACK: begin
                            if (is_full) begin
                                n_result.status = ST_FULL;
                            end else begin
                                cell_cmd.ins = 1'b1;
                                cell_at      = cnt_w[IW-1:0];
                                n_count      = r_count + CW'(1);
                            end
                        end
                        CMD_INS_POS: begin
                            if (!(pos_w < cnt_w)) begin
                                n_result.status = ST_BADPOS;
                            end else if (is_full) begin
                                n_result.status = ST_FULL;
                            end else begin
                                cell_cmd.ins = 1'b1;
                                n_count      = r_count + CW'(1);
                                if (pos_w == '0) begin
                                    cell_at = '0;
                                end else if (pos_w == cnt_w - CMPW'(1)) begin
                                    cell_at = cnt_w[IW-1:0];
                                end else begin
                                    cell_at = pos_w[IW-1:0];
                                end
                            end
                        end
                        CMD_SEARCH: begin
                            if (is_empty) begin
                                n_result.status = ST_EMPTY;
                            end else begin
                                n_done               = 1'b0;
                                cell_cmd.probe_start = 1'b1;
                                n_scan               = '0;
                                n_key                = i_cmd.team_name;
                            end
                        end
                        CMD_DEL_FRONT: begin
                            if (is_empty) begin
                                n_result.status = ST_EMPTY;
                            end else begin
                                cell_cmd.del = 1'b1;
                                n_count      = r_count - CW'(1);
                            end
                        end
                        CMD_DEL_BACK: begin
                            if (is_empty) begin
                                n_result.status = ST_EMPTY;
                            end else begin
                                n_count = r_count - CW'(1);
                            end
                        end
                        default: begin
                            n_result.status = ST_OK;
                        end
                    endcase
                end
            end
            S_SEARCH: begin
                if (hit) begin
                    n_done               = 1'b1;
                    cell_cmd.probe_clear = 1'b1;
                    n_result.found_index = scan_ext[3:0];
                end else if (scan_last) begin
                    n_done               = 1'b1;
                    cell_cmd.probe_clear = 1'b1;
                    n_result.status      = ST_NOTFOUND;
                end else begin
                    cell_cmd.probe_step = 1'b1;
                    n_scan              = r_scan + IW'(1);
                end
            end
            default: begin
                cell_cmd.probe_clear = 1'b1;
            end
        endcase
        n_result.entry_count = count_ext[4:0];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_scan   <= n_scan;
        r_key    <= n_key;
        r_result <= n_result;
    end

    // chain of record cells
    for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
        orl_cell #(
            .LIST_DEPTH (LIST_DEPTH),
            .IDX        (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (cell_cmd),
            .i_at         (cell_at),
            .i_new        (new_rec),
            .i_left       (cell_rec[(g == 0) ? 0 : g - 1]),
            .i_right      (cell_rec[(g == LIST_DEPTH - 1) ? g : g + 1]),
            .i_left_probe ((g == 0) ? 1'b0 : cell_probe[(g == 0) ? 0 : g - 1]),
            .i_key        (r_key),
            .o_rec        (cell_rec[g]),
            .o_probe      (cell_probe[g]),
            .o_match      (cell_match[g])
        );
    end

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

    // the search token sits in at most one cell
    `ORL_ASSERT_NOW(a_probe_onehot, 1'b1, $onehot0(cell_probe), "search token in two cells")
    // the list never holds more records than it has cells
    `ORL_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CW'(LIST_DEPTH), "record count over depth")
    // a count change always comes with a result strobe
    `ORL_ASSERT_NOW(a_count_done, !$stable(r_count), o_done, "count moved without result")
    // every transfer other than a search reports in the next cycle
    `ORL_ASSERT_NEXT(a_cmd_done, accept && (i_cmd.command != CMD_SEARCH), o_done, "missing result")

endmodule

// ----- sv/orl_cell.sv -----
// one list slot: holds a record, shifts with its neighbors, compares on search
module orl_cell #(
    parameter int LIST_DEPTH = orl_pkg::ORL_LIST_DEPTH,
    parameter int IDX        = 0
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  orl_pkg::t_cell_cmd            i_cmd,
    input  logic [$clog2(LIST_DEPTH)-1:0] i_at,
    input  orl_pkg::t_record              i_new,
    input  orl_pkg::t_record              i_left,
    input  orl_pkg::t_record              i_right,
    input  logic                          i_left_probe,
    input  logic [63:0]                   i_key,
    output orl_pkg::t_record              o_rec,
    output logic                          o_probe,
    output logic                          o_match
);
    import orl_pkg::*;

    localparam int IW = $clog2(LIST_DEPTH);
    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    t_record r_rec;
    t_record n_rec;
    logic    r_probe;
    logic    n_probe;

    // slot contents: load, take from left on insert, take from right on remove
    always_comb begin
        n_rec = r_rec;
        if (i_cmd.ins) begin
            if (MY_IDX == i_at) begin
                n_rec = i_new;
            end else if (MY_IDX > i_at) begin
                n_rec = i_left;
            end
        end else if (i_cmd.del) begin
            n_rec = i_right;
        end
    end

    // search token walks one slot per cycle
    always_comb begin
        n_probe = r_probe;
        if (i_cmd.probe_clear) begin
            n_probe = 1'b0;
        end else if (i_cmd.probe_start) begin
            n_probe = (IDX == 0);
        end else if (i_cmd.probe_step) begin
            n_probe = i_left_probe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rec <= n_rec;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe <= 1'b0;
        end else begin
            r_probe <= n_probe;
        end
    end

    assign o_rec   = r_rec;
    assign o_probe = r_probe;
    assign o_match = r_probe && (r_rec.team_name == i_key);

endmodule

// ----- tb/sv/tb.sv -----
// self-checking testbench for the ordered record list
`timescale 1ns / 100ps

module tb;
    import orl_pkg::*;

    localparam int DEPTH = ORL_LIST_DEPTH;
    localparam int RANDOM_ITEMS = 1200;
    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 40;
    localparam int REPORT_LIMIT = 10;
    localparam logic [63:0] ALL_ONES = '1;

    // codes outside the command set, which the block must ignore
    localparam logic [2:0] CMD_SPARE_6 = 3'd6;
    localparam logic [2:0] CMD_SPARE_7 = 3'd7;

    // command order used by the weighted mixes below
    localparam logic [2:0] CMD_ORDER [6] = '{CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_POS,
                                             CMD_SEARCH, CMD_DEL_FRONT, CMD_DEL_BACK};

    typedef enum int {PH_GROW, PH_SHRINK, PH_MIXED} t_phase;

    // cumulative percent cut points per phase, in CMD_ORDER order, rest are spare codes
    localparam int unsigned MIX_CUT [3][6] = '{'{25, 50, 75, 88, 93, 98},
                                               '{6, 12, 20, 35, 65, 97},
                                               '{15, 30, 48, 68, 83, 98}};

    logic    i_clk = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start = 1'b0;
    logic    busy;
    t_cmd_in i_cmd = '0;
    logic    o_done;
    t_result o_result;

    ordered_record_list dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (i_cmd),
        .o_done   (o_done),
        .o_result (o_result)
    );

    // clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    t_cmd_in     pending_cmds [$];
    t_result     expected_results [$];
    t_record     roster [DEPTH];
    int unsigned roster_len = 0;
    int unsigned plan_len = 0;
    logic [63:0] name_pool [8];
    bit          item_taken = 1'b0;
    int unsigned gap_left = 0;
    int unsigned steady_left = 0;
    int unsigned stall_cycles = 0;
    int unsigned error_count = 0;
    int unsigned accepted_count = 0;

    // predicted list: place a record at index at, later ones move up
    function automatic void insert_record(int unsigned at, t_record rec);
        for (int unsigned k = roster_len; k > at; k--) roster[k] = roster[k - 1];
        roster[at] = rec;
        roster_len++;
    endfunction

    // apply one command to the predicted list and return the result it gives
    function automatic t_result apply_command(t_cmd_in c);
        t_result     r;
        t_record     rec;
        int unsigned at;
        bit          hit;
        r = '0;
        hit = 1'b0;
        rec.team_name = c.team_name;
        rec.leader_name = c.leader_name;
        rec.language_name = c.language_name;
        rec.member_count = c.member_count;
        case (c.command)
            CMD_INS_FRONT, CMD_INS_BACK: begin
                if (roster_len >= DEPTH) r.status = ST_FULL;
                else insert_record(c.command == CMD_INS_FRONT ? 0 : roster_len, rec);
            end
            CMD_INS_POS: begin
                // position is checked before fullness
                if (roster_len == 0 || c.position > roster_len - 1) begin
                    r.status = ST_BADPOS;
                end else if (roster_len >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    // last valid nonzero position appends behind the tail
                    at = (c.position != 0 && c.position == roster_len - 1) ?
                         roster_len : c.position;
                    insert_record(at, rec);
                end
            end
            CMD_SEARCH: begin
                if (roster_len == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.status = ST_NOTFOUND;
                    // lowest matching index wins
                    for (int unsigned k = 0; k < roster_len && !hit; k++) begin
                        if (roster[k].team_name == c.team_name) begin
                            hit = 1'b1;
                            r.status = ST_OK;
                            r.found_index = 4'(k);
                        end
                    end
                end
            end
            CMD_DEL_FRONT: begin
                if (roster_len == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    for (int unsigned k = 0; k + 1 < roster_len; k++) roster[k] = roster[k + 1];
                    roster_len--;
                end
            end
            CMD_DEL_BACK: begin
                if (roster_len == 0) r.status = ST_EMPTY;
                else roster_len--;
            end
            default: ;
        endcase
        r.entry_count = 5'(roster_len);
        return r;
    endfunction

    // queue one command and track the list length it leads to
    function automatic void queue_item(logic [2:0] cmd, logic [3:0] pos, logic [63:0] team,
                                       logic [63:0] leader, logic [63:0] lang,
                                       logic [15:0] members);
        t_cmd_in c;
        c.command = cmd;
        c.position = pos;
        c.team_name = team;
        c.leader_name = leader;
        c.language_name = lang;
        c.member_count = members;
        pending_cmds.push_back(c);
        case (cmd)
            CMD_INS_FRONT, CMD_INS_BACK: if (plan_len < DEPTH) plan_len++;
            CMD_INS_POS: if (plan_len != 0 && pos < plan_len && plan_len < DEPTH) plan_len++;
            CMD_DEL_FRONT, CMD_DEL_BACK: if (plan_len != 0) plan_len--;
            default: ;
        endcase
    endfunction

    function automatic void queue_random(logic [2:0] cmd, logic [3:0] pos, logic [63:0] team);
        queue_item(cmd, pos, team, {$urandom, $urandom}, {$urandom, $urandom}, 16'($urandom));
    endfunction

    // names mostly from a small pool so that searches hit and duplicates occur
    function automatic logic [63:0] pick_name();
        if ($urandom_range(0, 99) < 85) return name_pool[$urandom_range(0, 7)];
        return {$urandom, $urandom};
    endfunction

    // positions mostly inside the current list
    function automatic logic [3:0] pick_position();
        if (plan_len != 0 && $urandom_range(0, 99) < 75) return 4'($urandom_range(0, plan_len - 1));
        return 4'($urandom_range(0, 15));
    endfunction

    function automatic logic [2:0] pick_command(t_phase phase);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        for (int k = 0; k < 6; k++) begin
            if (roll < MIX_CUT[int'(phase)][k]) return CMD_ORDER[k];
        end
        return $urandom_range(0, 1) ? CMD_SPARE_6 : CMD_SPARE_7;
    endfunction

    // idle cycles after a transfer: mostly none or short, a few long, some steady runs
    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (steady_left > 0) begin
            steady_left--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 2) begin
            steady_left = $urandom_range(20, 80);
            return 0;
        end
        if (roll < 55) return 0;
        if (roll < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // driver: next command at the falling edge once the last one is taken
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || item_taken) begin
            item_taken = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
                i_cmd <= pending_cmds.pop_front();
                start <= 1'b1;
                gap_left = pick_gap();
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor: check results, predict on each transfer, watch for stalls
    always @(posedge i_clk) begin : monitor
        t_result want;
        if (i_rst_n) begin
            if (o_done) begin
                if (expected_results.size() == 0) begin
                    if (error_count < REPORT_LIMIT)
                        $display("unexpected result: status %0d index %0d count %0d",
                                 o_result.status, o_result.found_index, o_result.entry_count);
                    error_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (o_result.status !== want.status ||
                        o_result.found_index !== want.found_index ||
                        o_result.entry_count !== want.entry_count) begin
                        if (error_count < REPORT_LIMIT)
                            $display("mismatch exp/got: status %0d/%0d index %0d/%0d count %0d/%0d",
                                     want.status, o_result.status,
                                     want.found_index, o_result.found_index,
                                     want.entry_count, o_result.entry_count);
                        error_count++;
                    end
                end
            end
            if (start && !busy) begin
                expected_results.push_back(apply_command(i_cmd));
                accepted_count++;
                item_taken = 1'b1;
            end
            if (o_done || (start && !busy)) stall_cycles = 0;
            else stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // stimulus, reset and end of run
    initial begin
        t_phase      phase;
        logic [2:0]  cmd;
        int unsigned span;
        int unsigned random_count;
        int unsigned total_items;
        random_count = 0;
        name_pool[0] = '0;
        name_pool[1] = ALL_ONES;
        for (int k = 2; k < 8; k++) name_pool[k] = {$urandom, $urandom};

        // empty list: search, both removes, positional insert at both ends of the range
        queue_random(CMD_SEARCH, 4'd0, name_pool[0]);
        queue_random(CMD_DEL_FRONT, 4'd0, name_pool[2]);
        queue_random(CMD_DEL_BACK, 4'd0, name_pool[2]);
        queue_random(CMD_INS_POS, 4'd0, name_pool[2]);
        queue_random(CMD_INS_POS, 4'd15, name_pool[2]);
        // build a list with all-ones and all-zeros records, covering each insert path
        queue_item(CMD_INS_BACK, 4'd15, ALL_ONES, ALL_ONES, ALL_ONES, 16'hffff);
        queue_item(CMD_INS_POS, 4'd0, '0, '0, '0, 16'h0000);
        queue_random(CMD_INS_POS, 4'd1, name_pool[2]);
        queue_random(CMD_INS_POS, 4'd1, name_pool[3]);
        queue_random(CMD_INS_POS, 4'd4, name_pool[4]);
        queue_random(CMD_INS_POS, 4'd15, name_pool[4]);
        queue_random(CMD_INS_FRONT, 4'd0, name_pool[2]);
        // duplicate name, all-ones name, a miss and the zero name
        queue_random(CMD_SEARCH, 4'd0, name_pool[2]);
        queue_random(CMD_SEARCH, 4'd0, ALL_ONES);
        queue_random(CMD_SEARCH, 4'd0, name_pool[4]);
        queue_random(CMD_SEARCH, 4'd0, '0);
        queue_random(CMD_SPARE_6, 4'd7, name_pool[5]);
        queue_random(CMD_SPARE_7, 4'd8, name_pool[6]);
        // drain down to empty, last one a remove back on a single record
        queue_random(CMD_DEL_FRONT, 4'd0, name_pool[2]);
        repeat (4) queue_random(CMD_DEL_BACK, 4'd0, name_pool[2]);
        queue_random(CMD_SEARCH, 4'd0, name_pool[2]);

        // eighteen random inserts toward full, then position 15, a valid position on a full list
        repeat (18) queue_random(CMD_ORDER[$urandom_range(0, 2)], pick_position(), pick_name());
        queue_random(CMD_INS_POS, 4'd15, pick_name());

        // random phases that grow, shrink or churn the list
        while (random_count < RANDOM_ITEMS) begin
            phase = t_phase'($urandom_range(0, 2));
            span = $urandom_range(20, 60);
            repeat (span) begin
                cmd = pick_command(phase);
                queue_random(cmd, pick_position(), pick_name());
                if (cmd != CMD_SPARE_6 && cmd != CMD_SPARE_7) random_count++;
            end
        end
        total_items = pending_cmds.size();

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted_count < total_items || expected_results.size() != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (error_count == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- ordered_record_list.f -----
+incdir+sv
sv/orl_pkg.sv
sv/orl_cell.sv
sv/ordered_record_list.sv
tb/sv/tb.sv
